/* sv/go_to_goal_pid_with_obstacle_avoid_core_assert.svh */
// ----------------------------------------------------------------------------
// Go-to-goal controller assertion macros
// Shared property templates for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_PID_WITH_OBSTACLE_AVOID_CORE_ASSERT_SVH
`define GO_TO_GOAL_PID_WITH_OBSTACLE_AVOID_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTG_ASSERT_NOW(lbl, ck, rn, ant, con, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTG_ASSERT_NEXT(lbl, ck, rn, ant, con, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
    else $error(msg);

`endif

/* sv/gtgpid_pkg.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Types, command codes, register indexes and constants shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none
package gtgpid_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps   = 17;

  localparam logic [16:0] HalfPiQ16   = 17'd102944;
  localparam logic [18:0] PiQ16       = 19'd205887;
  localparam logic [18:0] TwoPiQ16    = 19'd411775;
  localparam logic [14:0] TwoPiQ11    = 15'd12868;
  localparam logic [13:0] HalfTurnQ11 = 14'd6434;
  localparam logic [13:0] QuarterQ11  = 14'd3217;
  localparam logic [13:0] ThreeQtrQ11 = 14'd9651;

  localparam logic [14:0] GoalXReset       = 15'd18432;
  localparam logic [14:0] GoalYReset       = 15'd18432;
  localparam logic [14:0] AvoidRadiusReset = 15'd4096;
  localparam logic [23:0] KpHeadingReset   = 24'd360448;
  localparam logic [23:0] KiHeadingReset   = 24'd66;
  localparam logic [23:0] KpSpeedReset     = 24'd32768;
  localparam logic [23:0] KpAvoidReset     = 24'd39322;

  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_AVOID_RADIUS = 3'd2,
    REG_KP_HEADING   = 3'd3,
    REG_KI_HEADING   = 3'd4,
    REG_KP_SPEED     = 3'd5,
    REG_KP_AVOID     = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_SQ_SUM,
    OP_SQRT_STEP,
    OP_SQRT_END,
    OP_COR_INIT,
    OP_COR_STEP,
    OP_COR_END,
    OP_MUL_A,
    OP_ERR,
    OP_MUL_B,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQ_SUM,
    ST_SQRT,
    ST_SQRT_END,
    ST_COR_INIT,
    ST_COR,
    ST_COR_END,
    ST_MUL_A,
    ST_ERR,
    ST_MUL_B,
    ST_FINISH
  } state_t;

  // Which vector the shared units work on.
  localparam logic SEL_OBS  = 1'b0;
  localparam logic SEL_GOAL = 1'b1;

  typedef struct packed {
    op_t        op;
    logic       sel;
    logic [3:0] idx;
  } gtg_cmd_t;

  // CORDIC arctangent table, Q16 radians.
  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] v;
    unique case (i)
      4'd0:  v = 17'd51472;
      4'd1:  v = 17'd30386;
      4'd2:  v = 17'd16055;
      4'd3:  v = 17'd8150;
      4'd4:  v = 17'd4091;
      4'd5:  v = 17'd2047;
      4'd6:  v = 17'd1024;
      4'd7:  v = 17'd512;
      4'd8:  v = 17'd256;
      4'd9:  v = 17'd128;
      4'd10: v = 17'd64;
      4'd11: v = 17'd32;
      4'd12: v = 17'd16;
      4'd13: v = 17'd8;
      4'd14: v = 17'd4;
      4'd15: v = 17'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/go_to_goal_pid_with_obstacle_avoid_core.sv */
// The two 17-step square roots and the two 16-step CORDIC passes each run on one shared
// unit, so a new request is taken only once the previous one has finished.
// The next input is taken while a finished result still waits in the output register.
// Reset (rst_n low, synchronous) restores register defaults and clears the heading integral.
// ----------------------------------------------------------------------------
// Go-to-goal PI controller with obstacle avoidance
// Stream-in robot pose and obstacle, stream-out turn rate and forward speed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "go_to_goal_pid_with_obstacle_avoid_core_assert.svh"
module go_to_goal_pid_with_obstacle_avoid_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Pose request: own_x[15:0], own_y[31:16], own_heading[45:32],
  // obstacle_x[61:46], obstacle_y[77:62], zero fill [79:78].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,
  // Drive command: turn_rate[12:0], forward_speed[26:13], avoiding[27],
  // zero fill [31:28].
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  // Register writes; indexes beyond the list are ignored.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  gtgpid_pkg::gtg_cmd_t cmd;
  logic signed [12:0] turn_rate;
  logic signed [13:0] forward_speed;
  logic               avoiding;

  // Registers are writable at any cycle; the user writes only while idle.
  assign cfg_ready = 1'b1;

  // The sequencer owns the input and output handshakes and walks the datapath through:
  // load, obstacle distance, goal distance, both bearings, then PI math.
  gtgpid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gtgpid_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .own_x         ($signed(in_tdata[15:0])),
    .own_y         ($signed(in_tdata[31:16])),
    .own_heading   ($signed(in_tdata[45:32])),
    .obstacle_x    ($signed(in_tdata[61:46])),
    .obstacle_y    ($signed(in_tdata[77:62])),
    .turn_rate     (turn_rate),
    .forward_speed (forward_speed),
    .avoiding      (avoiding)
  );

  assign out_tdata = {4'd0, avoiding, forward_speed, turn_rate};

  // An accepted request keeps the block busy for the following cycle.
  `GTG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted while busy")
  // The turn command never falls below its lower clamp.
  `GTG_ASSERT_NOW(a_turn_range, clk, rst_n, out_tvalid, $signed(out_tdata[12:0]) >= -13'sd2048, "turn rate below clamp")
  // The speed command never leaves its clamp range.
  `GTG_ASSERT_NOW(a_speed_range, clk, rst_n, out_tvalid, ($signed(out_tdata[26:13]) >= -14'sd2048) && ($signed(out_tdata[26:13]) <= 14'sd4096), "speed out of clamp range")

endmodule
`default_nettype wire

/* sv/gtgpid_ctrl.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller sequencer
// Steps the datapath through square root, CORDIC and PI loop phases.
// ----------------------------------------------------------------------------
`default_nettype none
module gtgpid_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output gtgpid_pkg::gtg_cmd_t      cmd
);

  gtgpid_pkg::state_t state_r, state_nxt;
  logic       sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == gtgpid_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      gtgpid_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = gtgpid_pkg::ST_SQUARE;
          sel_nxt   = gtgpid_pkg::SEL_OBS;
        end
      end
      gtgpid_pkg::ST_SQUARE: state_nxt = gtgpid_pkg::ST_SQ_SUM;
      gtgpid_pkg::ST_SQ_SUM: begin
        state_nxt = gtgpid_pkg::ST_SQRT;
        cnt_nxt   = '0;
      end
      gtgpid_pkg::ST_SQRT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(gtgpid_pkg::SqrtSteps - 1)) begin
          state_nxt = gtgpid_pkg::ST_SQRT_END;
        end
      end
      gtgpid_pkg::ST_SQRT_END: begin
        if (sel_r == gtgpid_pkg::SEL_OBS) begin
          sel_nxt   = gtgpid_pkg::SEL_GOAL;
          state_nxt = gtgpid_pkg::ST_SQUARE;
        end else begin
          sel_nxt   = gtgpid_pkg::SEL_OBS;
          state_nxt = gtgpid_pkg::ST_COR_INIT;
        end
      end
      gtgpid_pkg::ST_COR_INIT: begin
        state_nxt = gtgpid_pkg::ST_COR;
        cnt_nxt   = '0;
      end
      gtgpid_pkg::ST_COR: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(gtgpid_pkg::CordicSteps - 1)) begin
          state_nxt = gtgpid_pkg::ST_COR_END;
        end
      end
      gtgpid_pkg::ST_COR_END: begin
        if (sel_r == gtgpid_pkg::SEL_OBS) begin
          sel_nxt   = gtgpid_pkg::SEL_GOAL;
          state_nxt = gtgpid_pkg::ST_COR_INIT;
        end else begin
          state_nxt = gtgpid_pkg::ST_MUL_A;
        end
      end
      gtgpid_pkg::ST_MUL_A: state_nxt = gtgpid_pkg::ST_ERR;
      gtgpid_pkg::ST_ERR:   state_nxt = gtgpid_pkg::ST_MUL_B;
      gtgpid_pkg::ST_MUL_B: state_nxt = gtgpid_pkg::ST_FINISH;
      gtgpid_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_nxt = gtgpid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gtgpid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = gtgpid_pkg::OP_NONE;
    cmd.sel       = sel_r;
    cmd.idx       = cnt_r[3:0];
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      gtgpid_pkg::ST_IDLE: begin
        if (in_tvalid) cmd.op = gtgpid_pkg::OP_LOAD;
      end
      gtgpid_pkg::ST_SQUARE:   cmd.op = gtgpid_pkg::OP_SQUARE;
      gtgpid_pkg::ST_SQ_SUM:   cmd.op = gtgpid_pkg::OP_SQ_SUM;
      gtgpid_pkg::ST_SQRT:     cmd.op = gtgpid_pkg::OP_SQRT_STEP;
      gtgpid_pkg::ST_SQRT_END: cmd.op = gtgpid_pkg::OP_SQRT_END;
      gtgpid_pkg::ST_COR_INIT: cmd.op = gtgpid_pkg::OP_COR_INIT;
      gtgpid_pkg::ST_COR:      cmd.op = gtgpid_pkg::OP_COR_STEP;
      gtgpid_pkg::ST_COR_END:  cmd.op = gtgpid_pkg::OP_COR_END;
      gtgpid_pkg::ST_MUL_A:    cmd.op = gtgpid_pkg::OP_MUL_A;
      gtgpid_pkg::ST_ERR:      cmd.op = gtgpid_pkg::OP_ERR;
      gtgpid_pkg::ST_MUL_B:    cmd.op = gtgpid_pkg::OP_MUL_B;
      gtgpid_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.op        = gtgpid_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = gtgpid_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gtgpid_pkg::ST_IDLE;
      sel_r       <= gtgpid_pkg::SEL_OBS;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/gtgpid_dp.sv */
// ----------------------------------------------------------------------------
// Go-to-goal controller datapath
// Configuration registers, shared square root and CORDIC units, PI loop math.
// ----------------------------------------------------------------------------
`default_nettype none
module gtgpid_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gtgpid_pkg::gtg_cmd_t  cmd,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [23:0]           cfg_data,
  input  wire logic signed [15:0]    own_x,
  input  wire logic signed [15:0]    own_y,
  input  wire logic signed [13:0]    own_heading,
  input  wire logic signed [15:0]    obstacle_x,
  input  wire logic signed [15:0]    obstacle_y,
  output logic signed [12:0]         turn_rate,
  output logic signed [13:0]         forward_speed,
  output logic                       avoiding
);

  // Configuration registers.
  logic [14:0] goal_x_r, goal_y_r, avoid_radius_r;
  logic [23:0] kp_heading_r, ki_heading_r, kp_speed_r, kp_avoid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r       <= gtgpid_pkg::GoalXReset;
      goal_y_r       <= gtgpid_pkg::GoalYReset;
      avoid_radius_r <= gtgpid_pkg::AvoidRadiusReset;
      kp_heading_r   <= gtgpid_pkg::KpHeadingReset;
      ki_heading_r   <= gtgpid_pkg::KiHeadingReset;
      kp_speed_r     <= gtgpid_pkg::KpSpeedReset;
      kp_avoid_r     <= gtgpid_pkg::KpAvoidReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtgpid_pkg::REG_GOAL_X:       goal_x_r       <= cfg_data[14:0];
        gtgpid_pkg::REG_GOAL_Y:       goal_y_r       <= cfg_data[14:0];
        gtgpid_pkg::REG_AVOID_RADIUS: avoid_radius_r <= cfg_data[14:0];
        gtgpid_pkg::REG_KP_HEADING:   kp_heading_r   <= cfg_data;
        gtgpid_pkg::REG_KI_HEADING:   ki_heading_r   <= cfg_data;
        gtgpid_pkg::REG_KP_SPEED:     kp_speed_r     <= cfg_data;
        gtgpid_pkg::REG_KP_AVOID:     kp_avoid_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers.
  logic signed [17:0] gdx_r, gdy_r, bdx_r, bdy_r;
  logic signed [13:0] hd_r;
  logic [31:0] sqx_r, sqy_r;
  logic [33:0] rem_r, res_r, bit_r;
  logic [16:0] obs_dist_r, goal_dist_r;
  logic signed [27:0] cx_r, cy_r;
  logic signed [18:0] cz_r;
  logic [13:0] obs_b_r, goal_b_r;
  logic [40:0] push_prod_r, speed_prod_r;
  logic signed [27:0] err_r;
  logic signed [31:0] integ_r;
  logic avoid_r;
  logic signed [52:0] p_prod_r;
  logic signed [56:0] i_prod_r;
  logic signed [12:0] turn_r;
  logic signed [13:0] speed_r;
  logic out_avoid_r;

  assign turn_rate     = turn_r;
  assign forward_speed = speed_r;
  assign avoiding      = out_avoid_r;

  // Vector currently worked on.
  logic signed [17:0] dx_c, dy_c, adx_c, ady_c;
  logic signed [35:0] mx_c, my_c;
  assign dx_c  = (cmd.sel == gtgpid_pkg::SEL_GOAL) ? gdx_r : bdx_r;
  assign dy_c  = (cmd.sel == gtgpid_pkg::SEL_GOAL) ? gdy_r : bdy_r;
  assign adx_c = dx_c[17] ? -dx_c : dx_c;
  assign ady_c = dy_c[17] ? -dy_c : dy_c;
  assign mx_c  = dx_c * dx_c;
  assign my_c  = dy_c * dy_c;

  // One square root step: one result bit per cycle.
  logic [34:0] trial_c;
  assign trial_c = {1'b0, res_r} + {1'b0, bit_r};

  // One CORDIC vectoring step.
  logic signed [27:0] xsh_c, ysh_c;
  logic signed [18:0] at_c;
  assign xsh_c = cx_r >>> cmd.idx;
  assign ysh_c = cy_r >>> cmd.idx;
  assign at_c  = $signed({2'b00, gtgpid_pkg::atan_q16(cmd.idx)});

  // Angle clamp, quadrant unfold and conversion to Q3.11.
  logic [16:0] zc_c;
  logic [18:0] a_c;
  logic [14:0] aq_c;
  logic [13:0] bear_c;
  always_comb begin
    if (cz_r < 0) begin
      zc_c = '0;
    end else if (cz_r > $signed({2'b00, gtgpid_pkg::HalfPiQ16})) begin
      zc_c = gtgpid_pkg::HalfPiQ16;
    end else begin
      zc_c = cz_r[16:0];
    end
    priority if (dx_c > 0 && dy_c > 0) begin
      a_c = {2'b00, zc_c};
    end else if (dx_c < 0 && dy_c > 0) begin
      a_c = gtgpid_pkg::PiQ16 - {2'b00, zc_c};
    end else if (dx_c < 0) begin
      a_c = gtgpid_pkg::PiQ16 + {2'b00, zc_c};
    end else begin
      a_c = gtgpid_pkg::TwoPiQ16 - {2'b00, zc_c};
    end
    aq_c = 15'(({1'b0, a_c} + 20'd16) >> 5);
    if (aq_c >= gtgpid_pkg::TwoPiQ11) aq_c = aq_c - gtgpid_pkg::TwoPiQ11;
    priority if (dy_c == 0) begin
      bear_c = (dx_c < 0) ? gtgpid_pkg::HalfTurnQ11 : 14'd0;
    end else if (dx_c == 0) begin
      bear_c = (dy_c > 0) ? gtgpid_pkg::QuarterQ11 : gtgpid_pkg::ThreeQtrQ11;
    end else begin
      bear_c = aq_c[13:0];
    end
  end

  // Bearing push, heading error and saturating integral.
  logic [25:0] push_c;
  logic avoid_c;
  logic signed [27:0] setb_c, err_c;
  logic signed [32:0] acc_c;
  logic signed [31:0] integ_c;
  always_comb begin
    push_c  = 26'(({1'b0, push_prod_r} + 42'd32768) >> 16);
    avoid_c = ({1'b0, obs_dist_r} <= {3'b000, avoid_radius_r});
    setb_c  = $signed({14'd0, goal_b_r});
    if (avoid_c) begin
      if (goal_b_r < obs_b_r) setb_c = setb_c - $signed({2'b00, push_c});
      else                    setb_c = setb_c + $signed({2'b00, push_c});
    end
    err_c = setb_c - 28'(hd_r);
    acc_c = 33'(integ_r) + 33'(err_c);
    if (acc_c > 33'sh0_7FFF_FFFF) begin
      integ_c = 32'sh7FFF_FFFF;
    end else if (acc_c < -33'sh0_8000_0000) begin
      integ_c = -32'sh8000_0000;
    end else begin
      integ_c = acc_c[31:0];
    end
  end

  // Output rounding and clamps.
  logic signed [57:0] tsum_c, tsh_c;
  logic [25:0] ssh_c;
  logic signed [12:0] turn_c;
  logic signed [13:0] speed_c;
  always_comb begin
    tsum_c = 58'(p_prod_r) + 58'(i_prod_r) + 58'sd32768;
    tsh_c  = tsum_c >>> 16;
    if (tsh_c < -58'sd2048)     turn_c = -13'sd2048;
    else if (tsh_c > 58'sd2048) turn_c = 13'sd2048;
    else                        turn_c = tsh_c[12:0];
    ssh_c = 26'(({1'b0, speed_prod_r} + 42'd32768) >> 16);
    if (ssh_c > 26'd4096) speed_c = 14'sd4096;
    else                  speed_c = $signed(ssh_c[13:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (cmd.op == gtgpid_pkg::OP_ERR) begin
      integ_r <= integ_c;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gtgpid_pkg::OP_LOAD: begin
        gdx_r <= $signed({3'b000, goal_x_r}) - 18'(own_x);
        gdy_r <= $signed({3'b000, goal_y_r}) - 18'(own_y);
        bdx_r <= 18'(obstacle_x) - 18'(own_x);
        bdy_r <= 18'(obstacle_y) - 18'(own_y);
        hd_r  <= own_heading;
      end
      gtgpid_pkg::OP_SQUARE: begin
        sqx_r <= mx_c[31:0];
        sqy_r <= my_c[31:0];
      end
      gtgpid_pkg::OP_SQ_SUM: begin
        rem_r <= {2'b00, sqx_r} + {2'b00, sqy_r};
        res_r <= '0;
        bit_r <= 34'h1_0000_0000;
      end
      gtgpid_pkg::OP_SQRT_STEP: begin
        if ({1'b0, rem_r} >= trial_c) begin
          rem_r <= rem_r - trial_c[33:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      gtgpid_pkg::OP_SQRT_END: begin
        if (cmd.sel == gtgpid_pkg::SEL_GOAL) goal_dist_r <= res_r[16:0];
        else                                 obs_dist_r  <= res_r[16:0];
      end
      gtgpid_pkg::OP_COR_INIT: begin
        cx_r <= $signed(28'({adx_c[16:0], 8'd0}));
        cy_r <= $signed(28'({ady_c[16:0], 8'd0}));
        cz_r <= '0;
      end
      gtgpid_pkg::OP_COR_STEP: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ysh_c;
          cy_r <= cy_r - xsh_c;
          cz_r <= cz_r + at_c;
        end else begin
          cx_r <= cx_r - ysh_c;
          cy_r <= cy_r + xsh_c;
          cz_r <= cz_r - at_c;
        end
      end
      gtgpid_pkg::OP_COR_END: begin
        if (cmd.sel == gtgpid_pkg::SEL_GOAL) goal_b_r <= bear_c;
        else                                 obs_b_r  <= bear_c;
      end
      gtgpid_pkg::OP_MUL_A: begin
        push_prod_r  <= kp_avoid_r * obs_dist_r;
        speed_prod_r <= kp_speed_r * goal_dist_r;
      end
      gtgpid_pkg::OP_ERR: begin
        err_r   <= err_c;
        avoid_r <= avoid_c;
      end
      gtgpid_pkg::OP_MUL_B: begin
        p_prod_r <= $signed({1'b0, kp_heading_r}) * err_r;
        i_prod_r <= $signed({1'b0, ki_heading_r}) * integ_r;
      end
      gtgpid_pkg::OP_FINISH: begin
        turn_r      <= turn_c;
        speed_r     <= speed_c;
        out_avoid_r <= avoid_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
